FILE: design/chip8_interpreter_core_top_assert.svh
// ----------------------------------------------------------------------------
// chip8_interpreter_core_top_assert.svh
// Assertion macros shared by the checker of the CHIP-8 core.
// ----------------------------------------------------------------------------
`ifndef CHIP8_INTERPRETER_CORE_TOP_ASSERT_SVH
`define CHIP8_INTERPRETER_CORE_TOP_ASSERT_SVH

// Implication checked at the same edge.
`define C8_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chip8 check failed");

// Implication checked at the next edge.
`define C8_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chip8 check failed");

`endif

FILE: design/chip8_pkg.sv
// ----------------------------------------------------------------------------
// chip8_pkg
// Types, constants and the hex font shared by the CHIP-8 core modules.
// ----------------------------------------------------------------------------
package chip8_pkg;

  localparam int ADDR_W    = 12;
  localparam int MEM_BYTES = 4096;
  localparam int SCR_W     = 64;
  localparam int SCR_H     = 32;
  localparam int ROW_W     = 5;

  localparam logic [ADDR_W-1:0] FONT_BASE = 12'h050;
  localparam logic [ADDR_W-1:0] FONT_END  = 12'h0A0;
  localparam logic [ADDR_W-1:0] PC_START  = 12'h200;

  // item modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_EXEC  = 2'd1;
  localparam logic [1:0] MODE_ROW   = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // opcode low bytes
  localparam logic [7:0] NN_CLS   = 8'hE0;
  localparam logic [7:0] NN_RET   = 8'hEE;
  localparam logic [7:0] NN_SKP   = 8'h9E;
  localparam logic [7:0] NN_SKNP  = 8'hA1;
  localparam logic [7:0] NN_GETDT = 8'h07;
  localparam logic [7:0] NN_SETDT = 8'h15;
  localparam logic [7:0] NN_SETST = 8'h18;
  localparam logic [7:0] NN_ADDI  = 8'h1E;
  localparam logic [7:0] NN_FONT  = 8'h29;
  localparam logic [7:0] NN_BCD   = 8'h33;
  localparam logic [7:0] NN_STORE = 8'h55;
  localparam logic [7:0] NN_LOAD  = 8'h65;

  // 8XYN ALU codes
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_RSB = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [3:0] REG_VF = 4'hF;
  localparam logic [3:0] REG_V0 = 4'h0;

  // controller states
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_MEMWR, S_MEMRD, S_ROWRD,
    S_FHI, S_FLO, S_DEC, S_VX, S_VY, S_EXEC,
    S_WFLAG, S_WX, S_DRD, S_DWR, S_DFLAG,
    S_BCD, S_STRD, S_STWR, S_LDRD, S_LDWR, S_FIN
  } state_t;

  // datapath commands
  typedef enum logic [4:0] {
    C_NONE, C_CLEAR, C_LOAD, C_MEMWR, C_MEMRD, C_ROWRD,
    C_FHI, C_FLO, C_DEC, C_VX, C_VY, C_EXEC,
    C_WFLAG, C_WX, C_DRD, C_DWR, C_DFLAG,
    C_BCD, C_STRD, C_STWR, C_LDRD, C_LDWR, C_PRESENT
  } cmd_t;

  // datapath status back to the controller
  typedef struct packed {
    logic [15:0] op;
    logic        loop_last;
    logic        clr_last;
  } status_t;

  localparam logic [639:0] FONT = {
    8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
    8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
    8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
    8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
    8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
    8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
    8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
    8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
  };

  // font byte by offset from the font base (offset below 80)
  function automatic logic [7:0] font_byte(input logic [6:0] idx);
    logic [9:0] base;
    base = 10'd639 - {idx, 3'b000};
    return FONT[base -: 8];
  endfunction

endpackage

FILE: design/chip8_interpreter_core_top.sv
// ----------------------------------------------------------------------------
// chip8_interpreter_core_top
// CHIP-8 core: program load, memory and display read-back, and execution of
// one instruction per execute beat.
// ----------------------------------------------------------------------------
//  channel | signals              | payload
//  in      | in_valid / in_ready  | mode address data_byte row_index key_mask random_byte
//  out     | out_valid / out_ready| program_counter opcode_done read_data display_row
//          |                      | display_changed sound_active delay_value
//
// After reset a clearing pass over all 4096 bytes loads memory (font at 0x050);
// no beat is accepted until it ends.
// Write, read and row beats pass one access state; an instruction steps through fetch,
// decode, VX and VY reads and execute, adds a VX write (after a VF write for flag-setting
// 8XYN forms), a read/write pair per DXYN row plus a VF write, a digit write per FX33
// digit or a pair per FX55/FX65 register: the single memory read port sets the pace.
// A held result stalls the next item only at its last cycle.
module chip8_interpreter_core_top #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [11:0] address,
  input  logic [7:0]  data_byte,
  input  logic [4:0]  row_index,
  input  logic [15:0] key_mask,
  input  logic [7:0]  random_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] program_counter,
  output logic [15:0] opcode_done,
  output logic [7:0]  read_data,
  output logic [63:0] display_row,
  output logic        display_changed,
  output logic        sound_active,
  output logic [7:0]  delay_value
);

  chip8_pkg::cmd_t    cmd;
  chip8_pkg::status_t status;

  // sequencer
  chip8_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // storage and execution
  chip8_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .mode            (mode),
    .address         (address),
    .data_byte       (data_byte),
    .row_index       (row_index),
    .key_mask        (key_mask),
    .random_byte     (random_byte),
    .program_counter (program_counter),
    .opcode_done     (opcode_done),
    .read_data       (read_data),
    .display_row     (display_row),
    .display_changed (display_changed),
    .sound_active    (sound_active),
    .delay_value     (delay_value)
  );

endmodule

FILE: design/chip8_ctrl.sv
// ----------------------------------------------------------------------------
// chip8_ctrl
// Sequencer of the CHIP-8 core: steps fetch, decode, execute and the
// multi-cycle loops, and owns both handshakes.
// ----------------------------------------------------------------------------
module chip8_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  output logic               out_valid,
  input  logic               out_ready,
  input  chip8_pkg::status_t status,
  output chip8_pkg::cmd_t    cmd
);

  chip8_pkg::state_t state, state_next;
  logic [3:0] opc;
  logic [3:0] n;
  logic [7:0] nn;
  logic       out_free;

  assign opc      = status.op[15:12];
  assign n        = status.op[3:0];
  assign nn       = status.op[7:0];
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == chip8_pkg::S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chip8_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // result beat held until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == chip8_pkg::S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      chip8_pkg::S_CLEAR: if (status.clr_last) state_next = chip8_pkg::S_IDLE;
      chip8_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            chip8_pkg::MODE_WRITE: state_next = chip8_pkg::S_MEMWR;
            chip8_pkg::MODE_EXEC:  state_next = chip8_pkg::S_FHI;
            chip8_pkg::MODE_ROW:   state_next = chip8_pkg::S_ROWRD;
            default:               state_next = chip8_pkg::S_MEMRD;
          endcase
        end
      end
      chip8_pkg::S_MEMWR: state_next = chip8_pkg::S_FIN;
      chip8_pkg::S_MEMRD: state_next = chip8_pkg::S_FIN;
      chip8_pkg::S_ROWRD: state_next = chip8_pkg::S_FIN;
      chip8_pkg::S_FHI:   state_next = chip8_pkg::S_FLO;
      chip8_pkg::S_FLO:   state_next = chip8_pkg::S_DEC;
      chip8_pkg::S_DEC:   state_next = chip8_pkg::S_VX;
      chip8_pkg::S_VX:    state_next = chip8_pkg::S_VY;
      chip8_pkg::S_VY:    state_next = chip8_pkg::S_EXEC;
      chip8_pkg::S_EXEC: begin
        state_next = chip8_pkg::S_FIN;
        case (opc)
          4'h6, 4'h7, 4'hC: state_next = chip8_pkg::S_WX;
          4'h8: begin
            case (n)
              chip8_pkg::ALU_MOV, chip8_pkg::ALU_OR,
              chip8_pkg::ALU_AND, chip8_pkg::ALU_XOR: state_next = chip8_pkg::S_WX;
              chip8_pkg::ALU_ADD, chip8_pkg::ALU_SUB, chip8_pkg::ALU_SHR,
              chip8_pkg::ALU_RSB, chip8_pkg::ALU_SHL: state_next = chip8_pkg::S_WFLAG;
              default: state_next = chip8_pkg::S_FIN;
            endcase
          end
          4'hD: state_next = (n == 4'h0) ? chip8_pkg::S_DFLAG : chip8_pkg::S_DRD;
          4'hF: begin
            case (nn)
              chip8_pkg::NN_GETDT: state_next = chip8_pkg::S_WX;
              chip8_pkg::NN_BCD:   state_next = chip8_pkg::S_BCD;
              chip8_pkg::NN_STORE: state_next = chip8_pkg::S_STRD;
              chip8_pkg::NN_LOAD:  state_next = chip8_pkg::S_LDRD;
              default:             state_next = chip8_pkg::S_FIN;
            endcase
          end
          default: state_next = chip8_pkg::S_FIN;
        endcase
      end
      chip8_pkg::S_WFLAG: state_next = chip8_pkg::S_WX;
      chip8_pkg::S_WX:    state_next = chip8_pkg::S_FIN;
      chip8_pkg::S_DRD:   state_next = chip8_pkg::S_DWR;
      chip8_pkg::S_DWR:
        state_next = status.loop_last ? chip8_pkg::S_DFLAG : chip8_pkg::S_DRD;
      chip8_pkg::S_DFLAG: state_next = chip8_pkg::S_FIN;
      chip8_pkg::S_BCD:   if (status.loop_last) state_next = chip8_pkg::S_FIN;
      chip8_pkg::S_STRD:  state_next = chip8_pkg::S_STWR;
      chip8_pkg::S_STWR:
        state_next = status.loop_last ? chip8_pkg::S_FIN : chip8_pkg::S_STRD;
      chip8_pkg::S_LDRD:  state_next = chip8_pkg::S_LDWR;
      chip8_pkg::S_LDWR:
        state_next = status.loop_last ? chip8_pkg::S_FIN : chip8_pkg::S_LDRD;
      chip8_pkg::S_FIN:   if (out_free) state_next = chip8_pkg::S_IDLE;
      default:            state_next = chip8_pkg::S_IDLE;
    endcase
  end

  // command to the datapath
  always_comb begin
    cmd = chip8_pkg::C_NONE;
    case (state)
      chip8_pkg::S_CLEAR: cmd = chip8_pkg::C_CLEAR;
      chip8_pkg::S_IDLE:  if (in_valid) cmd = chip8_pkg::C_LOAD;
      chip8_pkg::S_MEMWR: cmd = chip8_pkg::C_MEMWR;
      chip8_pkg::S_MEMRD: cmd = chip8_pkg::C_MEMRD;
      chip8_pkg::S_ROWRD: cmd = chip8_pkg::C_ROWRD;
      chip8_pkg::S_FHI:   cmd = chip8_pkg::C_FHI;
      chip8_pkg::S_FLO:   cmd = chip8_pkg::C_FLO;
      chip8_pkg::S_DEC:   cmd = chip8_pkg::C_DEC;
      chip8_pkg::S_VX:    cmd = chip8_pkg::C_VX;
      chip8_pkg::S_VY:    cmd = chip8_pkg::C_VY;
      chip8_pkg::S_EXEC:  cmd = chip8_pkg::C_EXEC;
      chip8_pkg::S_WFLAG: cmd = chip8_pkg::C_WFLAG;
      chip8_pkg::S_WX:    cmd = chip8_pkg::C_WX;
      chip8_pkg::S_DRD:   cmd = chip8_pkg::C_DRD;
      chip8_pkg::S_DWR:   cmd = chip8_pkg::C_DWR;
      chip8_pkg::S_DFLAG: cmd = chip8_pkg::C_DFLAG;
      chip8_pkg::S_BCD:   cmd = chip8_pkg::C_BCD;
      chip8_pkg::S_STRD:  cmd = chip8_pkg::C_STRD;
      chip8_pkg::S_STWR:  cmd = chip8_pkg::C_STWR;
      chip8_pkg::S_LDRD:  cmd = chip8_pkg::C_LDRD;
      chip8_pkg::S_LDWR:  cmd = chip8_pkg::C_LDWR;
      chip8_pkg::S_FIN:   if (out_free) cmd = chip8_pkg::C_PRESENT;
      default:            cmd = chip8_pkg::C_NONE;
    endcase
  end

endmodule

FILE: design/chip8_dpath.sv
// ----------------------------------------------------------------------------
// chip8_dpath
// Datapath of the CHIP-8 core: main memory, register file, frame buffer,
// return stack, timers and the result register, driven by controller commands.
// ----------------------------------------------------------------------------
module chip8_dpath #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  chip8_pkg::cmd_t    cmd,
  output chip8_pkg::status_t status,
  input  logic [1:0]         mode,
  input  logic [11:0]        address,
  input  logic [7:0]         data_byte,
  input  logic [4:0]         row_index,
  input  logic [15:0]        key_mask,
  input  logic [7:0]         random_byte,
  output logic [11:0]        program_counter,
  output logic [15:0]        opcode_done,
  output logic [7:0]         read_data,
  output logic [63:0]        display_row,
  output logic               display_changed,
  output logic               sound_active,
  output logic [7:0]         delay_value
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SIW = $clog2(STACK_DEPTH);

  // memories
  logic [7:0]  mem [chip8_pkg::MEM_BYTES];
  logic [7:0]  vreg [16];
  logic [63:0] fb [chip8_pkg::SCR_H];
  logic [11:0] stack [STACK_DEPTH];
  logic [15:0] vvalid;
  logic [31:0] fbvalid;

  // item registers
  logic [1:0]  m_mode;
  logic [11:0] m_addr;
  logic [7:0]  m_data;
  logic [4:0]  m_row;
  logic [15:0] m_keys;
  logic [7:0]  m_rnd;

  // architectural and working registers
  logic [11:0]    pc;
  logic [15:0]    ir;
  logic [SPW-1:0] sp;
  logic [7:0]     dt, st;
  logic [15:0]    op;
  logic [7:0]     op_hi;
  logic [7:0]     mem_q, vq, va, vb, res;
  logic           vq_ok, flag, coll, changed;
  logic [63:0]    fb_q;
  logic           fb_ok;
  logic [3:0]     cnt;
  logic [11:0]    clr;

  logic [3:0]  x, y, n;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic [7:0]  vval;
  logic [63:0] fbrow;
  logic [11:0] icnt;
  logic [4:0]  drow;

  assign x     = op[11:8];
  assign y     = op[7:4];
  assign n     = op[3:0];
  assign nn    = op[7:0];
  assign nnn   = op[11:0];
  assign vval  = vq_ok ? vq : 8'h00;
  assign fbrow = fb_ok ? fb_q : 64'h0;
  assign icnt  = ir[11:0] + {8'h00, cnt};
  assign drow  = vb[4:0] + {1'b0, cnt};

  // loop end per opcode
  logic loop_last;
  always_comb begin
    case (op[15:12])
      4'hD:    loop_last = (cnt == 4'(n - 4'd1));
      4'hF:    loop_last = (nn == chip8_pkg::NN_BCD) ? (cnt == 4'd2) : (cnt == x);
      default: loop_last = 1'b1;
    endcase
  end

  assign status.op        = op;
  assign status.loop_last = loop_last;
  assign status.clr_last  = (clr == 12'hFFF);

  // clearing-pass data: zero with the font in place
  logic [7:0] clr_data;
  always_comb begin
    clr_data = 8'h00;
    if (clr >= chip8_pkg::FONT_BASE && clr < chip8_pkg::FONT_END) begin
      clr_data = chip8_pkg::font_byte(7'(clr - chip8_pkg::FONT_BASE));
    end
  end

  // BCD digits of va
  logic [1:0]  bcd_h;
  logic [7:0]  bcd_r;
  logic [14:0] bcd_p;
  logic [3:0]  bcd_t;
  logic [7:0]  bcd_o;
  logic [7:0]  bcd_digit;
  always_comb begin
    if (va >= 8'd200) begin
      bcd_h = 2'd2;
      bcd_r = va - 8'd200;
    end else if (va >= 8'd100) begin
      bcd_h = 2'd1;
      bcd_r = va - 8'd100;
    end else begin
      bcd_h = 2'd0;
      bcd_r = va;
    end
    bcd_p = 15'(bcd_r[6:0]) * 15'd205;
    bcd_t = bcd_p[14:11];
    bcd_o = bcd_r - ({4'h0, bcd_t} << 3) - ({4'h0, bcd_t} << 1);
    case (cnt)
      4'd0:    bcd_digit = {6'h00, bcd_h};
      4'd1:    bcd_digit = {4'h0, bcd_t};
      default: bcd_digit = bcd_o;
    endcase
  end

  // 8XYN ALU on va and vval
  logic [8:0] add9;
  logic [7:0] alu_res;
  logic       alu_flag;
  always_comb begin
    add9     = {1'b0, va} + {1'b0, vval};
    alu_res  = vval;
    alu_flag = 1'b0;
    case (n)
      chip8_pkg::ALU_MOV: alu_res = vval;
      chip8_pkg::ALU_OR:  alu_res = va | vval;
      chip8_pkg::ALU_AND: alu_res = va & vval;
      chip8_pkg::ALU_XOR: alu_res = va ^ vval;
      chip8_pkg::ALU_ADD: begin alu_res = add9[7:0]; alu_flag = add9[8]; end
      chip8_pkg::ALU_SUB: begin alu_res = va - vval; alu_flag = (va >= vval); end
      chip8_pkg::ALU_SHR: begin alu_res = {1'b0, va[7:1]}; alu_flag = va[0]; end
      chip8_pkg::ALU_RSB: begin alu_res = vval - va; alu_flag = (vval >= va); end
      chip8_pkg::ALU_SHL: begin alu_res = {va[6:0], 1'b0}; alu_flag = va[7]; end
      default: ;
    endcase
  end

  // sprite row placed at x with wrap
  logic [63:0]  spr_base;
  logic [127:0] spr_dbl;
  logic [63:0]  spr_mask;
  assign spr_base = {mem_q, 56'h0};
  assign spr_dbl  = {spr_base, spr_base} >> va[5:0];
  assign spr_mask = spr_dbl[63:0];

  // main memory ports
  logic        mem_we, mem_re;
  logic [11:0] mem_wa, mem_ra;
  logic [7:0]  mem_wd;
  always_comb begin
    mem_we = 1'b0;
    mem_wa = m_addr;
    mem_wd = m_data;
    mem_re = 1'b0;
    mem_ra = m_addr;
    case (cmd)
      chip8_pkg::C_CLEAR: begin mem_we = 1'b1; mem_wa = clr; mem_wd = clr_data; end
      chip8_pkg::C_MEMWR: mem_we = 1'b1;
      chip8_pkg::C_BCD:   begin mem_we = 1'b1; mem_wa = icnt; mem_wd = bcd_digit; end
      chip8_pkg::C_STWR:  begin mem_we = 1'b1; mem_wa = icnt; mem_wd = vval; end
      chip8_pkg::C_MEMRD: mem_re = 1'b1;
      chip8_pkg::C_FHI:   begin mem_re = 1'b1; mem_ra = pc; end
      chip8_pkg::C_FLO:   begin mem_re = 1'b1; mem_ra = pc + 12'd1; end
      chip8_pkg::C_DRD, chip8_pkg::C_LDRD: begin mem_re = 1'b1; mem_ra = icnt; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (mem_re) mem_q <= mem[mem_ra];
  end

  // register file ports
  logic       v_we, v_re;
  logic [3:0] v_wa, v_ra;
  logic [7:0] v_wd;
  always_comb begin
    v_we = 1'b0;
    v_wa = x;
    v_wd = res;
    v_re = 1'b0;
    v_ra = x;
    case (cmd)
      chip8_pkg::C_WFLAG: begin v_we = 1'b1; v_wa = chip8_pkg::REG_VF; v_wd = {7'h0, flag}; end
      chip8_pkg::C_WX:    v_we = 1'b1;
      chip8_pkg::C_DFLAG: begin v_we = 1'b1; v_wa = chip8_pkg::REG_VF; v_wd = {7'h0, coll}; end
      chip8_pkg::C_LDWR:  begin v_we = 1'b1; v_wa = cnt; v_wd = mem_q; end
      chip8_pkg::C_VX:    v_re = 1'b1;
      chip8_pkg::C_VY: begin
        v_re = 1'b1;
        v_ra = (op[15:12] == 4'hB) ? chip8_pkg::REG_V0 : y;
      end
      chip8_pkg::C_STRD:  begin v_re = 1'b1; v_ra = cnt; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (v_we) vreg[v_wa] <= v_wd;
  end

  always_ff @(posedge clk) begin
    if (v_re) begin
      vq    <= vreg[v_ra];
      vq_ok <= vvalid[v_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vvalid <= '0;
    end else if (v_we) begin
      vvalid[v_wa] <= 1'b1;
    end
  end

  // frame buffer ports
  logic       fb_we, fb_re;
  logic [4:0] fb_ra;
  always_comb begin
    fb_we = (cmd == chip8_pkg::C_DWR);
    fb_re = 1'b0;
    fb_ra = m_row;
    case (cmd)
      chip8_pkg::C_ROWRD: fb_re = 1'b1;
      chip8_pkg::C_DRD:   begin fb_re = 1'b1; fb_ra = drow; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fb_we) fb[drow] <= fbrow ^ spr_mask;
  end

  always_ff @(posedge clk) begin
    if (fb_re) begin
      fb_q  <= fb[fb_ra];
      fb_ok <= fbvalid[fb_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fbvalid <= '0;
    end else if (cmd == chip8_pkg::C_EXEC && op[15:12] == 4'h0 && nn == chip8_pkg::NN_CLS) begin
      fbvalid <= '0;
    end else if (fb_we) begin
      fbvalid[drow] <= 1'b1;
    end
  end

  // return stack
  always_ff @(posedge clk) begin
    if (cmd == chip8_pkg::C_EXEC && op[15:12] == 4'h2 && sp < SPW'(STACK_DEPTH)) begin
      stack[sp[SIW-1:0]] <= pc;
    end
  end

  // item capture and working registers
  always_ff @(posedge clk) begin
    case (cmd)
      chip8_pkg::C_LOAD: begin
        m_mode <= mode;
        m_addr <= address;
        m_data <= data_byte;
        m_row  <= row_index;
        m_keys <= key_mask;
        m_rnd  <= random_byte;
      end
      chip8_pkg::C_FLO:  op_hi <= mem_q;
      chip8_pkg::C_DEC: begin
        op      <= {op_hi, mem_q};
        changed <= 1'b0;
      end
      chip8_pkg::C_VY:   va <= vval;
      chip8_pkg::C_EXEC: begin
        vb   <= vval;
        cnt  <= 4'd0;
        coll <= 1'b0;
        flag <= alu_flag;
        res  <= alu_res;
        case (op[15:12])
          4'h0:    if (nn == chip8_pkg::NN_CLS) changed <= 1'b1;
          4'h6:    res <= nn;
          4'h7:    res <= va + nn;
          4'hC:    res <= m_rnd & nn;
          4'hD:    changed <= 1'b1;
          4'hF:    res <= dt;
          default: ;
        endcase
      end
      chip8_pkg::C_DWR: begin
        coll <= coll | (|(fbrow & spr_mask));
        cnt  <= cnt + 4'd1;
      end
      chip8_pkg::C_BCD, chip8_pkg::C_STWR, chip8_pkg::C_LDWR: cnt <= cnt + 4'd1;
      default: ;
    endcase
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd == chip8_pkg::C_CLEAR) begin
      clr <= clr + 12'd1;
    end
  end

  // timers after the tick
  logic [7:0] dt_t, st_t;
  assign dt_t = (dt != 8'h00) ? dt - 8'd1 : dt;
  assign st_t = (st != 8'h00) ? st - 8'd1 : st;

  // architectural state
  logic key_hit;
  assign key_hit = m_keys[va[3:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= chip8_pkg::PC_START;
      ir <= '0;
      sp <= '0;
      dt <= '0;
      st <= '0;
    end else begin
      case (cmd)
        chip8_pkg::C_DEC: pc <= pc + 12'd2;
        chip8_pkg::C_EXEC: begin
          case (op[15:12])
            4'h0: begin
              if (nn == chip8_pkg::NN_RET && sp != '0) begin
                sp <= sp - SPW'(1);
                pc <= stack[SIW'(sp - SPW'(1))];
              end
            end
            4'h1: pc <= nnn;
            4'h2: begin
              if (sp < SPW'(STACK_DEPTH)) sp <= sp + SPW'(1);
              pc <= nnn;
            end
            4'h3: if (va == nn) pc <= pc + 12'd2;
            4'h4: if (va != nn) pc <= pc + 12'd2;
            4'h5: if (va == vval) pc <= pc + 12'd2;
            4'h9: if (va != vval) pc <= pc + 12'd2;
            4'hA: ir <= {4'h0, nnn};
            4'hB: pc <= nnn + {4'h0, vval};
            4'hE: begin
              if ((nn == chip8_pkg::NN_SKP && key_hit) ||
                  (nn == chip8_pkg::NN_SKNP && !key_hit)) begin
                pc <= pc + 12'd2;
              end
            end
            4'hF: begin
              case (nn)
                chip8_pkg::NN_SETDT: dt <= va;
                chip8_pkg::NN_SETST: st <= va;
                chip8_pkg::NN_ADDI:  ir <= ir + {8'h00, va};
                chip8_pkg::NN_FONT:
                  ir <= 16'(chip8_pkg::FONT_BASE) + ({8'h00, va} << 2) + {8'h00, va};
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        chip8_pkg::C_PRESENT: begin
          if (m_mode == chip8_pkg::MODE_EXEC) begin
            dt <= dt_t;
            st <= st_t;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  logic is_exec;
  assign is_exec = (m_mode == chip8_pkg::MODE_EXEC);

  always_ff @(posedge clk) begin
    if (cmd == chip8_pkg::C_PRESENT) begin
      program_counter <= pc;
      opcode_done     <= is_exec ? op : 16'h0;
      read_data       <= (m_mode == chip8_pkg::MODE_READ) ? mem_q : 8'h00;
      display_row     <= (m_mode == chip8_pkg::MODE_ROW) ? fbrow : 64'h0;
      display_changed <= is_exec & changed;
      sound_active    <= is_exec ? (st_t != 8'h00) : (st != 8'h00);
      delay_value     <= is_exec ? dt_t : dt;
    end
  end

endmodule

FILE: design/chip8_checker.sv
// ----------------------------------------------------------------------------
// chip8_checker
// Port-level checks of the CHIP-8 core, bound to the top level.
// ----------------------------------------------------------------------------
`include "chip8_interpreter_core_top_assert.svh"

module chip8_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] program_counter,
  input logic [15:0] opcode_done,
  input logic [7:0]  read_data,
  input logic [63:0] display_row,
  input logic        display_changed
);

  // a held result beat keeps its program counter
  `C8_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(program_counter))

  // the core is not ready in the cycle after taking a beat
  `C8_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // a display change only comes from an executed instruction
  `C8_ASSERT_NOW(a_change_exec, out_valid && display_changed, opcode_done != 16'h0)

  // a nonzero memory read result carries no instruction and no row
  `C8_ASSERT_NOW(a_read_alone, out_valid && read_data != 8'h00,
                 opcode_done == 16'h0 && display_row == 64'h0)

endmodule

bind chip8_interpreter_core_top chip8_checker u_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .program_counter (program_counter),
  .opcode_done     (opcode_done),
  .read_data       (read_data),
  .display_row     (display_row),
  .display_changed (display_changed)
);
